### sv/pbq_pkg.sv
// Shared types and constants for the power source / battery qualifier.
// Request, response and register-set structs, level encoding, register indexes.
// No dependencies.
package pbq_pkg;

   // Field widths fixed by the sample format
   localparam int MV_W     = 13;
   localparam int NEED_W   = 8;
   localparam int SRC_W    = 3;
   localparam int CSR_IDX_W = 3;

   // Source bit positions
   localparam int SRC_FIREWIRE = 0;
   localparam int SRC_USB      = 1;

   // Wake bit positions
   localparam int WAKE_USB      = 0;
   localparam int WAKE_FIREWIRE = 1;

   typedef enum logic [1:0] {
      LVL_UNKNOWN  = 2'd0,
      LVL_NORMAL   = 2'd1,
      LVL_LOW      = 2'd2,
      LVL_CRITICAL = 2'd3
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHUTOFF_MV      = 3'd0,
      CSR_LOW_MV          = 3'd1,
      CSR_RECOVER_MV      = 3'd2,
      CSR_CRITICAL_NEEDED = 3'd3,
      CSR_LOW_NEEDED      = 3'd4,
      CSR_GOOD_NEEDED     = 3'd5,
      CSR_SOURCE_NEEDED   = 3'd6,
      CSR_SUSPEND_MODE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [MV_W-1:0]  vbat_mv;
      logic             battery_ok;
      logic [SRC_W-1:0] raw_source;
      logic [SRC_W-1:0] source_observable;
      logic             take_wake;
   } req_type;

   typedef struct packed {
      logic [SRC_W-1:0] qualified_source;
      logic             source_unsettled;
      logic             adc_valid;
      logic             battery_low;
      logic             battery_critical;
      logic             charge_only;
      logic             suspended_flag;
      logic             usb_wake_seen;
      logic             firewire_wake_seen;
      logic [1:0]       battery_level;
      logic [1:0]       pending_wake;
      logic             shutdown_due;
   } rsp_type;

   typedef struct packed {
      logic [MV_W-1:0]   shutoff_mv;
      logic [MV_W-1:0]   low_mv;
      logic [MV_W-1:0]   recover_mv;
      logic [NEED_W-1:0] critical_needed;
      logic [NEED_W-1:0] low_needed;
      logic [NEED_W-1:0] good_needed;
      logic [NEED_W-1:0] source_needed;
      logic              suspend_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      shutoff_mv:      13'd3300,
      low_mv:          13'd3500,
      recover_mv:      13'd3600,
      critical_needed: 8'd3,
      low_needed:      8'd3,
      good_needed:     8'd3,
      source_needed:   8'd3,
      suspend_mode:    1'b0
   };

   // Source qualifier result toward the top level
   typedef struct packed {
      logic [SRC_W-1:0] stable;
      logic             settled;
   } src_stat_type;

   // Battery debouncer result toward the top level
   typedef struct packed {
      level_type level;
      logic      crit_met;
   } batt_stat_type;

endpackage

### sv/pbq_src_qual.sv
// Power source qualifier: repeat counting of the masked source pattern.
// Holds stable bits, validity, candidate pattern and its count.
// Depends on pbq_pkg.
module pbq_src_qual #(
   parameter int COUNT_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  pbq_pkg::cfg_type          cfg,
   input  logic [pbq_pkg::SRC_W-1:0] raw_source,
   input  logic [pbq_pkg::SRC_W-1:0] source_observable,
   output pbq_pkg::src_stat_type     stat
);
   import pbq_pkg::*;

   localparam int CW = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   logic [SRC_W-1:0]      stable_ff, stable_in;
   logic [SRC_W-1:0]      validity_ff, validity_in;
   logic [SRC_W-1:0]      cand_ff, cand_in;
   logic [COUNT_BITS-1:0] cand_cnt_ff, cand_cnt_in;
   logic                  qual_once_ff, qual_once_in;

   logic [SRC_W-1:0]      sample;
   logic [SRC_W-1:0]      stable_masked;
   logic [COUNT_BITS-1:0] cnt_step;

   // Next state of the qualifier for one sample
   always_comb begin
      sample        = raw_source & source_observable;
      stable_masked = stable_ff & source_observable;
      validity_in   = validity_ff;
      cand_in       = sample;
      cand_cnt_in   = cand_cnt_ff;
      qual_once_in  = qual_once_ff;
      stable_in     = stable_masked;
      cnt_step      = CNT_ONE;

      if (validity_ff != source_observable) begin
         // validity changed: restart qualification
         validity_in  = source_observable;
         cand_cnt_in  = CNT_ONE;
         qual_once_in = 1'b0;
      end else if (qual_once_ff && (stable_masked == sample)) begin
         cand_cnt_in = '0;
      end else begin
         if ((cand_ff != sample) || (cand_cnt_ff == '0)) begin
            cnt_step = CNT_ONE;
         end else begin
            cnt_step = (cand_cnt_ff == CNT_MAX) ? cand_cnt_ff : cand_cnt_ff + CNT_ONE;
         end
         if (CW'(cnt_step) >= CW'(cfg.source_needed)) begin
            // stable bits lie inside the validity mask, so the pattern replaces them
            stable_in    = sample;
            cand_cnt_in  = '0;
            qual_once_in = 1'b1;
         end else begin
            cand_cnt_in = cnt_step;
         end
      end

      stat.stable  = stable_in;
      stat.settled = (source_observable == {SRC_W{1'b1}}) && qual_once_in
                     && (cand_cnt_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= '0;
         validity_ff  <= '0;
         cand_ff      <= '0;
         cand_cnt_ff  <= '0;
         qual_once_ff <= 1'b0;
      end else if (en) begin
         stable_ff    <= stable_in;
         validity_ff  <= validity_in;
         cand_ff      <= cand_in;
         cand_cnt_ff  <= cand_cnt_in;
         qual_once_ff <= qual_once_in;
      end
   end

endmodule

### sv/pbq_batt_deb.sv
// Battery level debouncer: critical / low / good sample counters and level state.
// Invalid samples leave all state untouched.
// Depends on pbq_pkg.
module pbq_batt_deb #(
   parameter int COUNT_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  pbq_pkg::cfg_type         cfg,
   input  logic [pbq_pkg::MV_W-1:0] vbat_mv,
   input  logic                     battery_ok,
   output pbq_pkg::batt_stat_type   stat
);
   import pbq_pkg::*;

   localparam int CW = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   level_type             level_ff, level_in;
   logic [COUNT_BITS-1:0] crit_cnt_ff, crit_cnt_in;
   logic [COUNT_BITS-1:0] low_cnt_ff, low_cnt_in;
   logic [COUNT_BITS-1:0] good_cnt_ff, good_cnt_in;

   // Classify the sample and step the matching counter
   always_comb begin
      level_in    = level_ff;
      crit_cnt_in = crit_cnt_ff;
      low_cnt_in  = low_cnt_ff;
      good_cnt_in = good_cnt_ff;

      if (battery_ok) begin
         if (vbat_mv <= cfg.shutoff_mv) begin
            low_cnt_in  = '0;
            good_cnt_in = '0;
            crit_cnt_in = (crit_cnt_ff == CNT_MAX) ? crit_cnt_ff : crit_cnt_ff + CNT_ONE;
            if (CW'(crit_cnt_in) >= CW'(cfg.critical_needed)) begin
               level_in = LVL_CRITICAL;
            end
         end else begin
            crit_cnt_in = '0;
            if (vbat_mv <= cfg.low_mv) begin
               good_cnt_in = '0;
               low_cnt_in  = (low_cnt_ff == CNT_MAX) ? low_cnt_ff : low_cnt_ff + CNT_ONE;
               if ((CW'(low_cnt_in) >= CW'(cfg.low_needed)) && (level_ff != LVL_CRITICAL)) begin
                  level_in = LVL_LOW;
               end
            end else begin
               low_cnt_in = '0;
               if (vbat_mv >= cfg.recover_mv) begin
                  good_cnt_in = (good_cnt_ff == CNT_MAX) ? good_cnt_ff
                                                         : good_cnt_ff + CNT_ONE;
                  if (CW'(good_cnt_in) >= CW'(cfg.good_needed)) begin
                     level_in = LVL_NORMAL;
                  end
               end else begin
                  good_cnt_in = '0;
               end
            end
         end
      end

      stat.level    = level_in;
      stat.crit_met = CW'(crit_cnt_in) >= CW'(cfg.critical_needed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LVL_UNKNOWN;
         crit_cnt_ff <= '0;
         low_cnt_ff  <= '0;
         good_cnt_ff <= '0;
      end else if (en) begin
         level_ff    <= level_in;
         crit_cnt_ff <= crit_cnt_in;
         low_cnt_ff  <= low_cnt_in;
         good_cnt_ff <= good_cnt_in;
      end
   end

endmodule

### sv/power_source_battery_qualifier_core.sv
// A sample passes through the input register and then the result register; rsp_stall can hold it in either.
// Throughput: one sample per clock while rsp_stall is low; the input register and the result register
// let a new sample enter while a finished result waits on rsp_stall.
// Synchronous active-high reset clears all qualifier, battery and wake state
// and loads the register defaults; results and held samples are dropped.
module power_source_battery_qualifier_core #(
   parameter int COUNT_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // sample channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  pbq_pkg::req_type             req_data,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pbq_pkg::rsp_type             rsp_data,
   // register write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pbq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pbq_pkg::MV_W-1:0]     csr_wdata
);
   import pbq_pkg::*;

   cfg_type          cfg_ff;
   logic             in_vld_ff;
   req_type          in_ff;
   logic             rsp_vld_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [SRC_W-1:0] held_src_ff, held_src_in;
   logic [1:0]       wake_pend_ff, wake_pend_in;
   logic [1:0]       wake_hist_ff, wake_hist_in;
   logic [1:0]       wake_now;

   logic          advance;
   logic          work;
   src_stat_type  src_stat;
   batt_stat_type batt_stat;
   logic          batt_low;
   logic          batt_crit;

   // Pipeline control: result register frees when empty or taken
   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign work      = in_vld_ff && advance;
   assign req_stall = in_vld_ff && !advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SHUTOFF_MV:      cfg_ff.shutoff_mv      <= csr_wdata;
            CSR_LOW_MV:          cfg_ff.low_mv          <= csr_wdata;
            CSR_RECOVER_MV:      cfg_ff.recover_mv      <= csr_wdata;
            CSR_CRITICAL_NEEDED: cfg_ff.critical_needed <= csr_wdata[NEED_W-1:0];
            CSR_LOW_NEEDED:      cfg_ff.low_needed      <= csr_wdata[NEED_W-1:0];
            CSR_GOOD_NEEDED:     cfg_ff.good_needed     <= csr_wdata[NEED_W-1:0];
            CSR_SOURCE_NEEDED:   cfg_ff.source_needed   <= csr_wdata[NEED_W-1:0];
            CSR_SUSPEND_MODE:    cfg_ff.suspend_mode    <= csr_wdata[0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   pbq_src_qual #(
      .COUNT_BITS (COUNT_BITS)
   ) u_src_qual (
      .clock             (clock),
      .reset             (reset),
      .en                (work),
      .cfg               (cfg_ff),
      .raw_source        (in_ff.raw_source),
      .source_observable (in_ff.source_observable),
      .stat              (src_stat)
   );

   pbq_batt_deb #(
      .COUNT_BITS (COUNT_BITS)
   ) u_batt_deb (
      .clock      (clock),
      .reset      (reset),
      .en         (work),
      .cfg        (cfg_ff),
      .vbat_mv    (in_ff.vbat_mv),
      .battery_ok (in_ff.battery_ok),
      .stat       (batt_stat)
   );

   // Wake events on a settled source rising from none
   always_comb begin
      wake_now[WAKE_USB]      = src_stat.stable[SRC_USB];
      wake_now[WAKE_FIREWIRE] = src_stat.stable[SRC_FIREWIRE];
      held_src_in  = held_src_ff;
      wake_pend_in = wake_pend_ff;
      wake_hist_in = wake_hist_ff;
      if (src_stat.settled && (src_stat.stable != held_src_ff)) begin
         if (held_src_ff == '0) begin
            wake_pend_in = wake_pend_ff | wake_now;
            wake_hist_in = wake_hist_ff | wake_now;
         end
         held_src_in = src_stat.stable;
      end
   end

   // Result assembly
   always_comb begin
      batt_crit = batt_stat.level == LVL_CRITICAL;
      batt_low  = batt_crit || (batt_stat.level == LVL_LOW);

      rsp_in.qualified_source   = src_stat.stable;
      rsp_in.source_unsettled   = !src_stat.settled;
      rsp_in.adc_valid          = in_ff.battery_ok;
      rsp_in.battery_low        = batt_low;
      rsp_in.battery_critical   = batt_crit;
      rsp_in.charge_only        = src_stat.settled && (src_stat.stable != '0) && batt_low;
      rsp_in.suspended_flag     = cfg_ff.suspend_mode;
      rsp_in.usb_wake_seen      = wake_hist_in[WAKE_USB];
      rsp_in.firewire_wake_seen = wake_hist_in[WAKE_FIREWIRE];
      rsp_in.battery_level      = batt_stat.level;
      rsp_in.pending_wake       = wake_pend_in;
      rsp_in.shutdown_due       = src_stat.settled && batt_crit && (held_src_in == '0)
                                  && batt_stat.crit_met;
   end

   // Wake state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_src_ff  <= '0;
         wake_pend_ff <= '0;
         wake_hist_ff <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         if (work) begin
            held_src_ff  <= held_src_in;
            wake_pend_ff <= in_ff.take_wake ? 2'b00 : wake_pend_in;
            wake_hist_ff <= wake_hist_in;
         end
         if (advance) begin
            rsp_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         rsp_ff <= rsp_in;
      end
   end

   // Checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && rsp_vld_ff))
      else $error("input stalled while a stage is free");

   a_crit_implies_low: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (!rsp_ff.battery_critical || rsp_ff.battery_low))
      else $error("critical result without low flag");

   a_shutdown_no_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.shutdown_due) |->
         (rsp_ff.qualified_source == '0 && !rsp_ff.source_unsettled
          && rsp_ff.battery_level == LVL_CRITICAL))
      else $error("shutdown with a source present or unsettled");

   a_pending_in_history: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rsp_ff.pending_wake &
         ~{rsp_ff.firewire_wake_seen, rsp_ff.usb_wake_seen}) == 2'b00))
      else $error("pending wake not recorded in history");

endmodule

### verif/testbench.sv
// Testbench for power_source_battery_qualifier_core: source qualification, battery
// debounce, wake events and shutdown decisions, checked against an in-bench predictor.
// Depends on pbq_pkg and the core module.
module testbench;
   import pbq_pkg::*;

   localparam int CNT_BITS    = 8;
   localparam int CNT_MAX     = (1 << CNT_BITS) - 1;
   localparam int CYCLE_LIMIT = 500000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MV_W-1:0]      csr_wdata;

   power_source_battery_qualifier_core #(.COUNT_BITS(CNT_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock, period 8
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Predictor copy of registers and block state
   cfg_type     cfg = CFG_RESET;
   level_type   lvl = LVL_UNKNOWN;
   logic [7:0]  crit_cnt = '0;
   logic [7:0]  low_cnt = '0;
   logic [7:0]  good_cnt = '0;
   logic [2:0]  stable_src = '0;
   logic [2:0]  held_valid = '0;
   logic [2:0]  cand_src = '0;
   logic [7:0]  cand_cnt = '0;
   logic        qual_once = 1'b0;
   logic [2:0]  held_src = '0;
   logic [1:0]  wake_pend = '0;
   logic [1:0]  wake_hist = '0;

   rsp_type     status_due_q[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // Idling controls
   bit          snd_idle = 1'b1;
   bit          rcv_idle = 1'b1;
   int          rcv_wait = 0;
   int          hold_cycles = 0;

   // Random stimulus memory: sticky source pattern and voltage level
   logic [2:0]  src_pat = 3'b000;
   int          mv_base = 4000;

   function automatic logic [7:0] sat_inc(input logic [7:0] c);
      return (c < CNT_MAX) ? c + 8'd1 : c;
   endfunction

   // Expected status for one sample; advances the predictor state
   function automatic rsp_type qualify_sample(input req_type s);
      rsp_type    r;
      logic [2:0] valid;
      logic [2:0] smp;
      logic       settled;
      logic       crit;
      logic       low;
      valid = s.source_observable;
      smp   = s.raw_source & valid;

      // source qualification
      stable_src &= valid;
      if (held_valid != valid) begin
         held_valid = valid;
         cand_src   = smp;
         cand_cnt   = 8'd1;
         qual_once  = 1'b0;
      end else if (qual_once && stable_src == smp) begin
         cand_src = smp;
         cand_cnt = 8'd0;
      end else begin
         if (cand_src != smp || cand_cnt == 8'd0) begin
            cand_src = smp;
            cand_cnt = 8'd1;
         end else begin
            cand_cnt = sat_inc(cand_cnt);
         end
         if (cand_cnt >= cfg.source_needed) begin
            stable_src = (stable_src & ~valid) | smp;
            cand_cnt   = 8'd0;
            qual_once  = 1'b1;
         end
      end
      settled = (valid == 3'b111) && qual_once && (cand_cnt == 8'd0);

      // wake events on a rise from no source
      if (settled && stable_src != held_src) begin
         if (held_src == 3'b000) begin
            if (stable_src[SRC_USB]) begin
               wake_pend[WAKE_USB] = 1'b1;
               wake_hist[WAKE_USB] = 1'b1;
            end
            if (stable_src[SRC_FIREWIRE]) begin
               wake_pend[WAKE_FIREWIRE] = 1'b1;
               wake_hist[WAKE_FIREWIRE] = 1'b1;
            end
         end
         held_src = stable_src;
      end

      // battery debounce, only on a valid measurement
      if (s.battery_ok) begin
         if (s.vbat_mv <= cfg.shutoff_mv) begin
            low_cnt  = 8'd0;
            good_cnt = 8'd0;
            crit_cnt = sat_inc(crit_cnt);
            if (crit_cnt >= cfg.critical_needed) lvl = LVL_CRITICAL;
         end else begin
            crit_cnt = 8'd0;
            if (s.vbat_mv <= cfg.low_mv) begin
               good_cnt = 8'd0;
               low_cnt  = sat_inc(low_cnt);
               if (low_cnt >= cfg.low_needed && lvl != LVL_CRITICAL) lvl = LVL_LOW;
            end else begin
               low_cnt = 8'd0;
               if (s.vbat_mv >= cfg.recover_mv) begin
                  good_cnt = sat_inc(good_cnt);
                  if (good_cnt >= cfg.good_needed) lvl = LVL_NORMAL;
               end else begin
                  good_cnt = 8'd0;
               end
            end
         end
      end
      crit = (lvl == LVL_CRITICAL);
      low  = crit || (lvl == LVL_LOW);

      r.qualified_source   = stable_src;
      r.source_unsettled   = !settled;
      r.adc_valid          = s.battery_ok;
      r.battery_low        = low;
      r.battery_critical   = crit;
      r.charge_only        = settled && (stable_src != 3'b000) && low;
      r.suspended_flag     = cfg.suspend_mode;
      r.usb_wake_seen      = wake_hist[WAKE_USB];
      r.firewire_wake_seen = wake_hist[WAKE_FIREWIRE];
      r.battery_level      = lvl;
      r.pending_wake       = wake_pend;
      r.shutdown_due       = settled && crit && (held_src == 3'b000) &&
                             (crit_cnt >= cfg.critical_needed);
      if (s.take_wake) wake_pend = 2'b00;
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [12:0] got,
                              input logic [12:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Result side: compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result beat %h", rsp_data));
         end else begin
            want = status_due_q.pop_front();
            check_field("qualified_source", rsp_data.qualified_source, want.qualified_source);
            check_field("source_unsettled", rsp_data.source_unsettled, want.source_unsettled);
            check_field("adc_valid", rsp_data.adc_valid, want.adc_valid);
            check_field("battery_low", rsp_data.battery_low, want.battery_low);
            check_field("battery_critical", rsp_data.battery_critical, want.battery_critical);
            check_field("charge_only", rsp_data.charge_only, want.charge_only);
            check_field("suspended_flag", rsp_data.suspended_flag, want.suspended_flag);
            check_field("usb_wake_seen", rsp_data.usb_wake_seen, want.usb_wake_seen);
            check_field("firewire_wake_seen", rsp_data.firewire_wake_seen,
                        want.firewire_wake_seen);
            check_field("battery_level", rsp_data.battery_level, want.battery_level);
            check_field("pending_wake", rsp_data.pending_wake, want.pending_wake);
            check_field("shutdown_due", rsp_data.shutdown_due, want.shutdown_due);
         end
         rcv_wait = rcv_idle ? $urandom_range(0, 13) : 0;
      end
   end

   // Receiver stall: long hold-off first, then the per-beat wait
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (rcv_wait > 0) begin
         rsp_stall <= 1'b1;
         rcv_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one sample; valid stays high after the beat so back-to-back beats need no toggle
   task automatic offer_sample(input req_type s);
      int gap;
      gap = snd_idle ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      status_due_q.push_back(qualify_sample(s));
   endtask

   // Stop offering and wait until every expected status has come back
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [MV_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SHUTOFF_MV:      cfg.shutoff_mv      = val;
         CSR_LOW_MV:          cfg.low_mv          = val;
         CSR_RECOVER_MV:      cfg.recover_mv      = val;
         CSR_CRITICAL_NEEDED: cfg.critical_needed = val[NEED_W-1:0];
         CSR_LOW_NEEDED:      cfg.low_needed      = val[NEED_W-1:0];
         CSR_GOOD_NEEDED:     cfg.good_needed     = val[NEED_W-1:0];
         CSR_SOURCE_NEEDED:   cfg.source_needed   = val[NEED_W-1:0];
         CSR_SUSPEND_MODE:    cfg.suspend_mode    = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain, then program every register
   task automatic set_thresholds(input logic [12:0] shut, input logic [12:0] lowv,
                                 input logic [12:0] rec, input logic [12:0] crit_n,
                                 input logic [12:0] low_n, input logic [12:0] good_n,
                                 input logic [12:0] src_n, input logic [12:0] susp);
      settle_block();
      write_register(CSR_SHUTOFF_MV, shut);
      write_register(CSR_LOW_MV, lowv);
      write_register(CSR_RECOVER_MV, rec);
      write_register(CSR_CRITICAL_NEEDED, crit_n);
      write_register(CSR_LOW_NEEDED, low_n);
      write_register(CSR_GOOD_NEEDED, good_n);
      write_register(CSR_SOURCE_NEEDED, src_n);
      write_register(CSR_SUSPEND_MODE, susp);
   endtask

   function automatic req_type mk_sample(input int mv, input bit ok, input bit [2:0] raw,
                                         input bit [2:0] obs, input bit take);
      req_type s;
      s.vbat_mv           = MV_W'(mv);
      s.battery_ok        = ok;
      s.raw_source        = raw;
      s.source_observable = obs;
      s.take_wake         = take;
      return s;
   endfunction

   // Mostly steady sources and voltages near the thresholds, with some noise
   function automatic req_type next_sample();
      req_type s;
      int      v;
      if ($urandom_range(0, 7) == 0)
         src_pat = ($urandom_range(0, 2) == 0) ? 3'b000 : 3'($urandom_range(0, 7));
      if ($urandom_range(0, 15) == 0) begin
         case ($urandom_range(0, 4))
            0: mv_base = cfg.shutoff_mv;
            1: mv_base = cfg.low_mv;
            2: mv_base = cfg.recover_mv;
            default: mv_base = $urandom_range(0, 8191);
         endcase
      end
      v = mv_base + $urandom_range(0, 40) - 20;
      if (v < 0) v = 0;
      if (v > 8191) v = 8191;
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 8191);
      s.vbat_mv           = MV_W'(v);
      s.battery_ok        = ($urandom_range(0, 9) != 0);
      s.source_observable = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
      s.raw_source        = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : src_pat;
      s.take_wake         = ($urandom_range(0, 3) == 0);
      return s;
   endfunction

   // Default registers: threshold edges, source qualification, wakes, shutdown
   task automatic test_directed();
      offer_sample(mk_sample(0, 0, 3'b000, 3'b000, 0));
      offer_sample(mk_sample(8191, 1, 3'b111, 3'b111, 0));
      offer_sample(mk_sample(8191, 1, 3'b111, 3'b111, 0));
      offer_sample(mk_sample(8191, 1, 3'b111, 3'b111, 0));
      offer_sample(mk_sample(3600, 1, 3'b111, 3'b111, 1));
      offer_sample(mk_sample(3599, 1, 3'b111, 3'b111, 0));
      offer_sample(mk_sample(3500, 1, 3'b111, 3'b111, 0));
      offer_sample(mk_sample(3301, 1, 3'b111, 3'b111, 0));
      offer_sample(mk_sample(3500, 1, 3'b111, 3'b111, 0));
      offer_sample(mk_sample(3300, 1, 3'b000, 3'b111, 0));
      offer_sample(mk_sample(3300, 1, 3'b000, 3'b111, 0));
      offer_sample(mk_sample(0, 1, 3'b000, 3'b111, 0));
      // charging alone rises without a wake
      offer_sample(mk_sample(0, 1, 3'b100, 3'b111, 0));
      offer_sample(mk_sample(0, 1, 3'b100, 3'b111, 0));
      offer_sample(mk_sample(0, 1, 3'b100, 3'b111, 0));
      // partial validity clears stable bits
      offer_sample(mk_sample(4000, 1, 3'b100, 3'b011, 0));
      offer_sample(mk_sample(4000, 1, 3'b000, 3'b111, 0));
      offer_sample(mk_sample(4000, 1, 3'b000, 3'b111, 0));
      offer_sample(mk_sample(4000, 1, 3'b000, 3'b111, 0));
      // usb rise from nothing
      offer_sample(mk_sample(4000, 1, 3'b010, 3'b111, 0));
      offer_sample(mk_sample(4000, 1, 3'b010, 3'b111, 0));
      offer_sample(mk_sample(4000, 1, 3'b010, 3'b111, 0));
      offer_sample(mk_sample(4000, 1, 3'b010, 3'b111, 1));
      offer_sample(mk_sample(8191, 1, 3'b001, 3'b111, 1));
   endtask

   // Zero counts via masked writes, suspend set
   task automatic test_zero_thresholds();
      set_thresholds(13'd3300, 13'd3500, 13'd3600, 13'h100, 13'h100, 13'h100, 13'h100,
                     13'h1fff);
      repeat (150) offer_sample(next_sample());
   endtask

   // Largest counts: long steady runs drive the counters into saturation
   task automatic test_counter_saturation();
      set_thresholds(13'd3300, 13'd3500, 13'd3600, 13'h1eff, 13'd255, 13'd255, 13'd255,
                     13'd0);
      snd_idle = 1'b0;
      repeat (280) offer_sample(mk_sample(100, 1, 3'b011, 3'b111, 0));
      repeat (280) offer_sample(mk_sample(8000, 1, 3'b000, 3'b111, 1));
      snd_idle = 1'b1;
      repeat (30) offer_sample(next_sample());
   endtask

   // Receiver holds off while samples keep coming, so the input stalls
   task automatic test_result_backpressure();
      set_thresholds(13'd3300, 13'd3500, 13'd3600, 13'd2, 13'd2, 13'd2, 13'd2, 13'd0);
      hold_cycles = 300;
      snd_idle = 1'b0;
      repeat (40) offer_sample(next_sample());
      snd_idle = 1'b1;
      settle_block();
   endtask

   // Random samples over several register settings, with idle stretches
   task automatic test_random_samples();
      int          shut;
      int          lowv;
      int          rec;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            1: set_thresholds(13'd0, 13'd0, 13'h1fff, 13'd1, 13'd1, 13'd1, 13'd1, 13'd1);
            2: set_thresholds(13'h1fff, 13'h1fff, 13'h1fff, 13'd1, 13'd2, 13'd1, 13'd5,
                              13'd0);
            default: begin
               shut = $urandom_range(2500, 3800);
               lowv = shut + $urandom_range(0, 300);
               rec  = lowv + $urandom_range(0, 300);
               if (ph == 4) rec = shut - 100;
               set_thresholds(13'(shut), 13'(lowv), 13'(rec), 13'($urandom_range(1, 6)),
                              13'($urandom_range(1, 6)), 13'($urandom_range(1, 6)),
                              13'($urandom_range(1, 6)), 13'($urandom_range(0, 1)));
            end
         endcase
         mv_base = cfg.low_mv;
         for (int i = 0; i < 180; i++) begin
            if (i % 50 == 0) begin
               snd_idle = ($urandom_range(0, 3) != 0);
               rcv_idle = ($urandom_range(0, 3) != 0);
            end
            offer_sample(next_sample());
         end
      end
      snd_idle = 1'b1;
      rcv_idle = 1'b1;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_zero_thresholds();
      test_counter_saturation();
      test_result_backpressure();
      test_random_samples();
      settle_block();

      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
sv/pbq_pkg.sv
sv/pbq_src_qual.sv
sv/pbq_batt_deb.sv
sv/power_source_battery_qualifier_core.sv
verif/testbench.sv
